/* design/hcut_pkg.sv */
// ----------------------------------------------------------------------------
// hcut_pkg
// Shared types, sizes and codes for the height cell update tracker.
// ----------------------------------------------------------------------------
package hcut_pkg;

   localparam int MAX_UPDATES = 16;
   localparam int HEIGHT_BITS = 16;
   localparam int TAG_BITS    = 16;
   localparam int CNT_BITS    = $clog2(MAX_UPDATES + 1);

   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_REDUCE
   } state_type;

   // One stored update.
   typedef struct packed {
      logic                          valid;
      logic [TAG_BITS-1:0]           tag;
      logic signed [HEIGHT_BITS-1:0] low;
      logic signed [HEIGHT_BITS-1:0] high;
   } slot_type;

   // Running extremes handed from cell to cell.
   typedef struct packed {
      logic                          valid;
      logic signed [HEIGHT_BITS-1:0] low;
      logic signed [HEIGHT_BITS-1:0] high;
   } part_type;

   // Control for one cell of the row.
   typedef struct packed {
      logic                          shift_en;
      logic                          append_en;
      logic [TAG_BITS-1:0]           key;
      logic signed [HEIGHT_BITS-1:0] low;
      logic signed [HEIGHT_BITS-1:0] high;
   } cell_ctl_type;

   // Commands from the top level to the row.
   typedef struct packed {
      logic                          append_en;
      logic [CNT_BITS-1:0]           append_idx;
      logic                          remove_en;
      logic [TAG_BITS-1:0]           key;
      logic signed [HEIGHT_BITS-1:0] low;
      logic signed [HEIGHT_BITS-1:0] high;
   } row_cmd_type;

endpackage

/* design/hcut_if.sv */
// ----------------------------------------------------------------------------
// hcut_if
// Valid/ready channels for requests and responses of the tracker.
// ----------------------------------------------------------------------------
interface hcut_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   req_type;
   logic [hcut_pkg::TAG_BITS-1:0]          tag_id;
   logic signed [hcut_pkg::HEIGHT_BITS-1:0] z;
   logic                                   last;

   modport source (output valid, req_type, tag_id, z, last, input ready);
   modport sink   (input valid, req_type, tag_id, z, last, output ready);
endinterface

interface hcut_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             status;
   logic                                   occupied;
   logic signed [hcut_pkg::HEIGHT_BITS-1:0] cell_min_z;
   logic signed [hcut_pkg::HEIGHT_BITS-1:0] cell_max_z;
   logic [hcut_pkg::CNT_BITS-1:0]          entry_count;

   modport source (output valid, status, occupied, cell_min_z, cell_max_z, entry_count,
                   input ready);
   modport sink   (input valid, status, occupied, cell_min_z, cell_max_z, entry_count,
                   output ready);
endinterface

/* design/hcut_cell.sv */
// ----------------------------------------------------------------------------
// hcut_cell
// One slot of the update list with its share of the min/max reduction.
// ----------------------------------------------------------------------------
module hcut_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  hcut_pkg::cell_ctl_type  ctl,
   input  hcut_pkg::slot_type      nbr_slot,
   input  hcut_pkg::part_type      nbr_part,
   output hcut_pkg::slot_type      slot,
   output hcut_pkg::part_type      part,
   output logic                    match
);

   hcut_pkg::slot_type slot_ff, slot_in;
   hcut_pkg::part_type part_ff, part_in;

   always_comb begin
      match = slot_ff.valid && (slot_ff.tag == ctl.key);

      slot_in = slot_ff;
      if (ctl.shift_en) begin
         slot_in = nbr_slot;
      end else if (ctl.append_en) begin
         slot_in.valid = 1'b1;
         slot_in.tag   = ctl.key;
         slot_in.low   = ctl.low;
         slot_in.high  = ctl.high;
      end

      // Valid slots form a prefix, so an empty slot just passes what comes behind it.
      part_in = nbr_part;
      if (slot_ff.valid) begin
         part_in.valid = 1'b1;
         part_in.low   = slot_ff.low;
         part_in.high  = slot_ff.high;
         if (nbr_part.valid) begin
            if (nbr_part.low < slot_ff.low) begin
               part_in.low = nbr_part.low;
            end
            if (nbr_part.high > slot_ff.high) begin
               part_in.high = nbr_part.high;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
         part_ff.valid <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         part_ff <= part_in;
      end
   end

   assign slot = slot_ff;
   assign part = part_ff;

endmodule

/* design/hcut_row.sv */
// ----------------------------------------------------------------------------
// hcut_row
// Row of slot cells: append at the fill point, remove with compaction,
// and a running min/max that moves one cell toward the head each cycle.
// ----------------------------------------------------------------------------
module hcut_row (
   input  logic                   clock,
   input  logic                   reset,
   input  hcut_pkg::row_cmd_type  cmd,
   output logic                   found,
   output hcut_pkg::part_type     head_part
);

   localparam int N = hcut_pkg::MAX_UPDATES;

   hcut_pkg::slot_type     slots [N+1];
   hcut_pkg::part_type     parts [N+1];
   hcut_pkg::cell_ctl_type ctls  [N];
   logic [N-1:0]           tag_hits;
   logic [N-1:0]           hit_prefix;

   assign slots[N] = '0;
   assign parts[N] = '0;

   always_comb begin
      hit_prefix[0] = tag_hits[0];
      for (int i = 1; i < N; i++) begin
         hit_prefix[i] = hit_prefix[i-1] | tag_hits[i];
      end
   end

   assign found     = hit_prefix[N-1];
   assign head_part = parts[0];

   for (genvar g = 0; g < N; g++) begin : g_cell
      always_comb begin
         ctls[g].shift_en  = cmd.remove_en && hit_prefix[g];
         ctls[g].append_en = cmd.append_en &&
                             (cmd.append_idx == hcut_pkg::CNT_BITS'(g));
         ctls[g].key       = cmd.key;
         ctls[g].low       = cmd.low;
         ctls[g].high      = cmd.high;
      end

      hcut_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctls[g]),
         .nbr_slot (slots[g+1]),
         .nbr_part (parts[g+1]),
         .slot     (slots[g]),
         .part     (parts[g]),
         .match    (tag_hits[g])
      );
   end

endmodule

/* design/height_cell_update_tracker.sv */
// ----------------------------------------------------------------------------
// height_cell_update_tracker
// Keeps a list of tagged height updates for one map cell and the cell extremes.
// ----------------------------------------------------------------------------
// A point without last gives no response; points stream one per cycle while idle and the response
// slot is free. A point with last, or a remove whose id is absent, gives its registered response
// in the cycle after it is accepted. A remove that hits compacts the row, then the min/max runs
// along the row of MAX_UPDATES cells toward the head before the response is loaded.
// Synchronous active-high reset empties the list and clears the extremes and the run.
module height_cell_update_tracker (
   input  logic            clock,
   input  logic            reset,
   hcut_req_if.sink        req_bus,
   hcut_rsp_if.source      rsp_bus
);

   localparam int CW = hcut_pkg::CNT_BITS;
   localparam int HB = hcut_pkg::HEIGHT_BITS;

   hcut_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         red_cnt_ff, red_cnt_in;
   logic                  run_active_ff, run_active_in;
   logic signed [HB-1:0]  run_low_ff, run_low_in;
   logic signed [HB-1:0]  run_high_ff, run_high_in;
   logic signed [HB-1:0]  total_low_ff, total_low_in;
   logic signed [HB-1:0]  total_high_ff, total_high_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   logic signed [HB-1:0]  rsp_min_ff, rsp_min_in;
   logic signed [HB-1:0]  rsp_max_ff, rsp_max_in;

   logic                  out_free;
   logic                  fire;
   logic                  is_point;
   logic                  is_remove;
   logic                  is_full;
   logic                  rsp_load;
   logic                  found;
   hcut_pkg::part_type    head_part;
   hcut_pkg::row_cmd_type cmd;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == hcut_pkg::ST_IDLE) && out_free;
   assign fire          = req_bus.valid && req_bus.ready;
   assign is_point      = fire && (req_bus.req_type == hcut_pkg::REQ_ADD);
   assign is_remove     = fire && (req_bus.req_type == hcut_pkg::REQ_REMOVE);
   assign is_full       = (count_ff == CW'(hcut_pkg::MAX_UPDATES));

   // Run extremes including the current point.
   always_comb begin
      run_low_in  = run_low_ff;
      run_high_in = run_high_ff;
      if (!run_active_ff) begin
         run_low_in  = req_bus.z;
         run_high_in = req_bus.z;
      end else begin
         if (req_bus.z < run_low_ff) begin
            run_low_in = req_bus.z;
         end
         if (req_bus.z > run_high_ff) begin
            run_high_in = req_bus.z;
         end
      end
      run_active_in = run_active_ff;
      if (is_point) begin
         run_active_in = !req_bus.last;
      end
   end

   always_comb begin
      cmd.append_en  = is_point && req_bus.last && !is_full;
      cmd.append_idx = count_ff;
      cmd.remove_en  = is_remove;
      cmd.key        = req_bus.tag_id;
      cmd.low        = run_low_in;
      cmd.high       = run_high_in;
   end

   hcut_row u_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .found     (found),
      .head_part (head_part)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      red_cnt_in    = red_cnt_ff;
      total_low_in  = total_low_ff;
      total_high_in = total_high_ff;
      rsp_load      = 1'b0;
      rsp_status_in = hcut_pkg::STATUS_DONE;

      unique case (state_ff)
         hcut_pkg::ST_IDLE: begin
            if (is_point && req_bus.last) begin
               rsp_load = 1'b1;
               if (is_full) begin
                  rsp_status_in = hcut_pkg::STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  if (count_ff == '0) begin
                     total_low_in  = run_low_in;
                     total_high_in = run_high_in;
                  end else begin
                     if (run_low_in < total_low_ff) begin
                        total_low_in = run_low_in;
                     end
                     if (run_high_in > total_high_ff) begin
                        total_high_in = run_high_in;
                     end
                  end
               end
            end else if (is_remove) begin
               if (found) begin
                  count_in   = count_ff - CW'(1);
                  red_cnt_in = '0;
                  state_in   = hcut_pkg::ST_REDUCE;
               end else begin
                  rsp_load      = 1'b1;
                  rsp_status_in = hcut_pkg::STATUS_NOT_FOUND;
               end
            end
         end
         hcut_pkg::ST_REDUCE: begin
            // The head cell holds the full extremes once the row has settled.
            if (red_cnt_ff == CW'(hcut_pkg::MAX_UPDATES)) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = hcut_pkg::ST_IDLE;
                  if (head_part.valid) begin
                     total_low_in  = head_part.low;
                     total_high_in = head_part.high;
                  end else begin
                     total_low_in  = '0;
                     total_high_in = '0;
                  end
               end
            end else begin
               red_cnt_in = red_cnt_ff + CW'(1);
            end
         end
         default: begin
            state_in = hcut_pkg::ST_IDLE;
         end
      endcase

      rsp_count_in = count_in;
      rsp_min_in   = total_low_in;
      rsp_max_in   = total_high_in;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hcut_pkg::ST_IDLE;
         count_ff      <= '0;
         red_cnt_ff    <= '0;
         run_active_ff <= 1'b0;
         run_low_ff    <= '0;
         run_high_ff   <= '0;
         total_low_ff  <= '0;
         total_high_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         red_cnt_ff    <= red_cnt_in;
         run_active_ff <= run_active_in;
         if (is_point) begin
            run_low_ff  <= run_low_in;
            run_high_ff <= run_high_in;
         end
         total_low_ff  <= total_low_in;
         total_high_ff <= total_high_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_min_ff    <= rsp_min_in;
         rsp_max_ff    <= rsp_max_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.occupied    = (rsp_count_ff != '0);
   assign rsp_bus.cell_min_z  = rsp_min_ff;
   assign rsp_bus.cell_max_z  = rsp_max_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

endmodule
